// ===== rtl/spimcds_pkg.sv =====
// ----------------------------------------------------------------------------
// spimcds_pkg
// Shared types and constants of the spi master command/data sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package spimcds_pkg;

  localparam int CMD_DEPTH  = 16;
  localparam int DATA_DEPTH = 256;
  localparam int CMD_AW     = $clog2(CMD_DEPTH);
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int CCNT_W     = $clog2(CMD_DEPTH + 1);

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;

  localparam logic [BYTE_W-1:0] TMO_RESET = 8'd2;
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 3'd0,
    KIND_START = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_TICK  = 3'd3,
    KIND_READ  = 3'd4,
    KIND_STOP  = 3'd5
  } kind_e;

  // one input item without its kind
  typedef struct packed {
    logic              notify_each_byte;
    logic              no_tx;
    logic              no_rx;
    logic              capture_cmd_rx;
    logic [7:0]        data_count;
    logic [4:0]        cmd_count;
    logic [BYTE_W-1:0] value;
    logic [7:0]        buffer_index;
    logic              buffer_area;
  } item_t;

  typedef struct packed {
    logic [CCNT_W-1:0] cmd_cnt;
    logic [7:0]        data_cnt;
    logic              capture;
    logic              no_rx;
    logic              no_tx;
    logic              notify_each;
  } setup_t;

  typedef struct packed {
    logic               cmd_we;
    logic [CMD_AW-1:0]  cmd_waddr;
    logic               data_we;
    logic [DATA_AW-1:0] data_waddr;
    logic [BYTE_W-1:0]  wdata;
    logic [CMD_AW-1:0]  cmd_raddr;
    logic [DATA_AW-1:0] data_raddr;
  } buf_req_t;

  // result flags; the bytes come from the buffer read registers
  typedef struct packed {
    logic tx_valid;
    logic tx_fill;
    logic from_data;
    logic rd_valid;
    logic chip_select;
    logic dstart;
    logic notify;
    logic done;
    logic terr;
    logic rej;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/spimcds_bufs.sv =====
// ----------------------------------------------------------------------------
// spimcds_bufs
// Command and data byte buffers, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none

module spimcds_bufs (
  input  wire                             clk_i,
  input  wire                             adv_i,
  input  spimcds_pkg::buf_req_t           req_i,
  output logic [spimcds_pkg::BYTE_W-1:0]  cmd_rdata_o,
  output logic [spimcds_pkg::BYTE_W-1:0]  data_rdata_o
);
  import spimcds_pkg::*;

  logic [BYTE_W-1:0] cmd_mem  [CMD_DEPTH];
  logic [BYTE_W-1:0] data_mem [DATA_DEPTH];

  always_ff @(posedge clk_i) begin
    if (adv_i && req_i.cmd_we) begin
      cmd_mem[req_i.cmd_waddr] <= req_i.wdata;
    end
    // read data holds while the result waits
    if (adv_i) begin
      cmd_rdata_o <= cmd_mem[req_i.cmd_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && req_i.data_we) begin
      data_mem[req_i.data_waddr] <= req_i.wdata;
    end
    if (adv_i) begin
      data_rdata_o <= data_mem[req_i.data_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spimcds_ctrl.sv =====
// ----------------------------------------------------------------------------
// spimcds_ctrl
// Transaction state, timeout counter and per-item decode.
// ----------------------------------------------------------------------------
`default_nettype none

module spimcds_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire [spimcds_pkg::KIND_W-1:0] kind_i,
  input  spimcds_pkg::item_t           item_i,
  input  wire                          cfg_we_i,
  input  wire [7:0]                    cfg_data_i,
  output spimcds_pkg::buf_req_t        req_o,
  output spimcds_pkg::res_t            res_o
);
  import spimcds_pkg::*;

  logic [7:0]        bp_q, bp_d;
  logic              busy_q, busy_d;
  logic              cmd_done_q, cmd_done_d;
  logic [7:0]        tmo_q, tmo_d;
  logic [7:0]        tmo_cfg_q;
  setup_t            setup_q, setup_d;

  logic [7:0]        pos;
  logic              data_check;
  logic [CCNT_W-1:0] ccnt;
  logic [7:0]        dcnt;

  // clamp the start counts to the buffer depths; a zero command count becomes one
  always_comb begin
    ccnt = item_i.cmd_count[CCNT_W-1:0];
    if (item_i.cmd_count == 5'd0) begin
      ccnt = CCNT_W'(1);
    end else if (item_i.cmd_count > 5'(CMD_DEPTH)) begin
      ccnt = CCNT_W'(CMD_DEPTH);
    end
    dcnt = item_i.data_count;
    if ({1'b0, item_i.data_count} > 9'(DATA_DEPTH)) begin
      dcnt = 8'(DATA_DEPTH);
    end
  end

  always_comb begin
    bp_d       = bp_q;
    busy_d     = busy_q;
    cmd_done_d = cmd_done_q;
    tmo_d      = tmo_q;
    setup_d    = setup_q;
    pos        = bp_q + 8'd1;
    data_check = 1'b0;
    req_o      = '0;
    res_o      = '0;
    req_o.wdata = item_i.value;

    unique case (kind_e'(kind_i))
      KIND_LOAD: begin
        if (!item_i.buffer_area) begin
          req_o.cmd_we    = (item_i.buffer_index < 8'(CMD_DEPTH));
          req_o.cmd_waddr = item_i.buffer_index[CMD_AW-1:0];
        end else begin
          req_o.data_we    = ({1'b0, item_i.buffer_index} < 9'(DATA_DEPTH));
          req_o.data_waddr = item_i.buffer_index[DATA_AW-1:0];
        end
      end
      KIND_START: begin
        if (busy_q) begin
          res_o.rej = 1'b1;
        end else begin
          setup_d.cmd_cnt     = ccnt;
          setup_d.data_cnt    = dcnt;
          setup_d.capture     = item_i.capture_cmd_rx;
          setup_d.no_rx       = item_i.no_rx;
          setup_d.no_tx       = item_i.no_tx;
          setup_d.notify_each = item_i.notify_each_byte;
          busy_d         = 1'b1;
          cmd_done_d     = 1'b0;
          bp_d           = '0;
          tmo_d          = tmo_cfg_q;
          res_o.tx_valid = 1'b1;
          req_o.cmd_raddr = '0;
        end
      end
      KIND_DONE: begin
        if (busy_q) begin
          if (!cmd_done_q) begin
            req_o.cmd_we    = setup_q.capture && (bp_q < 8'(CMD_DEPTH));
            req_o.cmd_waddr = bp_q[CMD_AW-1:0];
            if (pos < 8'(setup_q.cmd_cnt)) begin
              bp_d            = pos;
              res_o.tx_valid  = 1'b1;
              req_o.cmd_raddr = pos[CMD_AW-1:0];
            end else begin
              pos          = '0;
              bp_d         = '0;
              cmd_done_d   = 1'b1;
              res_o.dstart = 1'b1;
              data_check   = 1'b1;
            end
          end else begin
            req_o.data_we    = !setup_q.no_rx && ({1'b0, bp_q} < 9'(DATA_DEPTH));
            req_o.data_waddr = bp_q[DATA_AW-1:0];
            bp_d             = pos;
            data_check       = 1'b1;
          end
          if (data_check) begin
            if (setup_q.data_cnt != 8'd0 && pos < setup_q.data_cnt) begin
              res_o.tx_valid   = 1'b1;
              res_o.tx_fill    = setup_q.no_tx;
              res_o.from_data  = 1'b1;
              req_o.data_raddr = pos[DATA_AW-1:0];
              res_o.notify     = setup_q.notify_each;
            end else begin
              busy_d       = 1'b0;
              tmo_d        = '0;
              res_o.notify = 1'b1;
              res_o.done   = 1'b1;
            end
          end
        end
      end
      KIND_TICK: begin
        if (tmo_q != 8'd0) begin
          tmo_d = tmo_q - 8'd1;
          if (tmo_q == 8'd1 && busy_q) begin
            busy_d     = 1'b0;
            res_o.terr = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (!item_i.buffer_area) begin
          res_o.rd_valid  = (item_i.buffer_index < 8'(CMD_DEPTH));
          req_o.cmd_raddr = item_i.buffer_index[CMD_AW-1:0];
        end else begin
          res_o.rd_valid   = ({1'b0, item_i.buffer_index} < 9'(DATA_DEPTH));
          res_o.from_data  = 1'b1;
          req_o.data_raddr = item_i.buffer_index[DATA_AW-1:0];
        end
      end
      KIND_STOP: begin
        busy_d = 1'b0;
        tmo_d  = '0;
      end
      default: begin
      end
    endcase

    res_o.chip_select = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q       <= '0;
      busy_q     <= 1'b0;
      cmd_done_q <= 1'b0;
      tmo_q      <= '0;
      setup_q    <= '0;
    end else if (adv_i) begin
      bp_q       <= bp_d;
      busy_q     <= busy_d;
      cmd_done_q <= cmd_done_d;
      tmo_q      <= tmo_d;
      setup_q    <= setup_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_cfg_q <= TMO_RESET;
    end else if (cfg_we_i) begin
      tmo_cfg_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spi_master_cmd_data_sequencer.sv =====
// ----------------------------------------------------------------------------
// spi_master_cmd_data_sequencer
// Sequencer for one spi master transaction: command phase, then data phase.
// ----------------------------------------------------------------------------
// Usage: every input transfer on s_axis carries one item; tuser is the kind
// (load, start, byte done, tick, read, stop). Each item gives exactly one
// result transfer on m_axis with the byte to shift out, chip select and the
// status strobes. A byte done item hands in the byte received for the byte
// sent last. The timeout in ticks is written on the cfg channel while idle;
// the block does not enforce this. The result is registered and valid in the
// cycle after the transfer. One item is taken every cycle: the decode and the
// buffer access of an item fit between the state registers and the result
// register, the buffers having one write and one registered read port each.
// When the receiver stalls, the result register and the buffer read data
// hold, and s_axis_tready drops until the result is taken (a new item is
// still taken in the same cycle that the held result leaves).
// Reset clears the transaction state and the result valid and sets the
// timeout to two ticks; buffer contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_master_cmd_data_sequencer (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // buffer_area, buffer_index, value, cmd_count, data_count, capture_cmd_rx,
  // no_rx, no_tx, notify_each_byte, zero fill
  input  wire [spimcds_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // kind
  input  wire [spimcds_pkg::KIND_W-1:0]       s_axis_tuser,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // tx_valid, tx_byte, chip_select, data_phase_start, byte_notify, done_res,
  // timeout_error, start_rejected, busy_res, read_byte
  output logic [spimcds_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [7:0]                           cfg_data_i
);
  import spimcds_pkg::*;

  item_t             item;
  buf_req_t          req;
  res_t              res, res_q;
  logic              out_valid_q, out_valid_d;
  logic              adv;
  logic [BYTE_W-1:0] cmd_rdata, data_rdata, rdata;
  logic [BYTE_W-1:0] tx_byte, read_byte;

  assign item          = item_t'(s_axis_tdata[$bits(item_t)-1:0]);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign adv           = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  spimcds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .kind_i     (s_axis_tuser),
    .item_i     (item),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .req_o      (req),
    .res_o      (res)
  );

  spimcds_bufs u_bufs (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .req_i        (req),
    .cmd_rdata_o  (cmd_rdata),
    .data_rdata_o (data_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign rdata     = res_q.from_data ? data_rdata : cmd_rdata;
  assign tx_byte   = !res_q.tx_valid ? '0 : (res_q.tx_fill ? FILL_BYTE : rdata);
  assign read_byte = res_q.rd_valid ? rdata : '0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {read_byte, res_q.chip_select, res_q.rej, res_q.terr,
                          res_q.done, res_q.notify, res_q.dstart,
                          res_q.chip_select, tx_byte, res_q.tx_valid};

endmodule

`default_nettype wire

// ===== rtl/spimcds_checker.sv =====
// ----------------------------------------------------------------------------
// spimcds_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spimcds_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire [spimcds_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_cs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9] == m_axis_tdata[15])
    else $error("chip select differs from busy");

  // completion and timeout both leave the block idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[12] || m_axis_tdata[13]) |-> !m_axis_tdata[15])
    else $error("transaction end with busy still set");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
    else $error("tx byte nonzero without tx valid");

  a_dstart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[15] || m_axis_tdata[12])
    else $error("data phase start outside a transaction");

endmodule

bind spi_master_cmd_data_sequencer spimcds_checker u_spimcds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
